FILE: src/tdss_pkg.sv
// Shared constants, segment tables and word assembly for the seven-segment shifter.
package tdss_pkg;

  localparam int WordBits = 32;

  // Reciprocal of 1000 scaled by 2**26, exact for every 16-bit value.
  localparam int unsigned Recip1000 = 67109;
  localparam int unsigned Recip1000Shift = 26;
  localparam int unsigned Thousand = 1000;
  localparam int unsigned Hundred = 100;
  localparam int unsigned Ten = 10;
  // x*41 >> 12 equals x/100 below 1000, x*205 >> 11 equals x/10 below 100.
  localparam int unsigned Recip100 = 41;
  localparam int unsigned Recip10 = 205;

  // Layout PCDE--------GFAB, used for the hundreds and the units.
  localparam logic [15:0] OuterSeg [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };

  // Layout ----PCDEGFAB----, used for the tens.
  localparam logic [15:0] MiddleSeg [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };

  function automatic logic [31:0] seg_word(logic [3:0] hund, logic [3:0] tens,
                                           logic [3:0] unit);
    logic [15:0] hi_pat;
    logic [15:0] lo_pat;
    hi_pat = OuterSeg[hund];
    lo_pat = MiddleSeg[tens] | OuterSeg[unit];
    return {hi_pat, lo_pat};
  endfunction

endpackage

FILE: src/tdss_digits.sv
// Pipeline that splits a value into three decimal digits and builds the segment word.
module tdss_digits import tdss_pkg::*; #(
  parameter int WORD_BITS = WordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          display_value_i,
  output logic                 word_valid_o,
  input  logic                 word_ready_i,
  output logic [WORD_BITS-1:0] word_o
);

  localparam int NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   rdy;

  // Stage payloads.
  logic [15:0]          s1_val_q;
  logic [6:0]           s1_quo_q;
  logic [9:0]           s2_rem_q;
  logic [9:0]           s3_rem_q;
  logic [3:0]           s3_hund_q;
  logic [6:0]           s4_rem_q;
  logic [3:0]           s4_hund_q;
  logic [6:0]           s5_rem_q;
  logic [3:0]           s5_hund_q;
  logic [3:0]           s5_tens_q;
  logic [WORD_BITS-1:0] s6_word_q;

  logic [32:0] quo_prod;
  logic [16:0] rem_diff;
  logic [15:0] hund_prod;
  logic [9:0]  rem2_diff;
  logic [14:0] tens_prod;
  logic [6:0]  unit_diff;
  logic [WORD_BITS-1:0] word_d;

  // A stage takes a new beat when it is empty or its content moves on.
  assign rdy[NumStages] = word_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign in_stall_o   = !rdy[0];
  assign word_valid_o = vld_q[NumStages-1];
  assign word_o       = s6_word_q;

  assign quo_prod  = 33'(display_value_i) * 33'(Recip1000);
  assign rem_diff  = 17'(s1_val_q) - 17'(s1_quo_q) * 17'(Thousand);
  assign hund_prod = 16'(s2_rem_q) * 16'(Recip100);
  assign rem2_diff = s3_rem_q - 10'(s3_hund_q) * 10'(Hundred);
  assign tens_prod = 15'(s4_rem_q) * 15'(Recip10);
  assign unit_diff = s5_rem_q - 7'(s5_tens_q) * 7'(Ten);
  assign word_d    = WORD_BITS'(seg_word(s5_hund_q, s5_tens_q, unit_diff[3:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s1_val_q <= display_value_i;
      s1_quo_q <= quo_prod[Recip1000Shift +: 7];
    end
    if (rdy[1] && vld_q[0]) begin
      s2_rem_q <= rem_diff[9:0];
    end
    if (rdy[2] && vld_q[1]) begin
      s3_rem_q  <= s2_rem_q;
      s3_hund_q <= hund_prod[15:12];
    end
    if (rdy[3] && vld_q[2]) begin
      s4_rem_q  <= rem2_diff[6:0];
      s4_hund_q <= s3_hund_q;
    end
    if (rdy[4] && vld_q[3]) begin
      s5_rem_q  <= s4_rem_q;
      s5_hund_q <= s4_hund_q;
      s5_tens_q <= tens_prod[14:11];
    end
    if (rdy[5] && vld_q[4]) begin
      s6_word_q <= word_d;
    end
  end

endmodule

FILE: src/tdss_cell.sv
// One bit cell of the serial output chain.
module tdss_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic next_bit_i,
  output logic bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bit_q <= load_bit_i;
    end else if (shift_i) begin
      bit_q <= next_bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

FILE: src/three_digit_seven_segment_shifter_top.sv
// Top level: digit pipeline feeding a chain of bit cells that shifts the segment word out.
// The first bit of a value is offered once the value has passed the digit pipeline and
// its word is loaded into the bit cells. Throughput: one value per 32 output beats,
// one bit per cycle while out_stall_i is low, set by the bit-cell chain; the next word
// is computed while the current one shifts, so words follow without gaps.
// Reset clears the valid flags and the bit counter only; no blank word is sent.
module three_digit_seven_segment_shifter_top import tdss_pkg::*; #(
  parameter int WORD_BITS = WordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] display_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        serial_bit_o,
  output logic        latch_now_o
);

  localparam int CntW = $clog2(WORD_BITS);

  logic                 word_valid;
  logic                 word_ready;
  logic [WORD_BITS-1:0] word;

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 last;
  logic                 out_fire;
  logic                 load;
  logic                 shift;
  logic [WORD_BITS-1:0] cell_bits;

  tdss_digits #(
    .WORD_BITS(WORD_BITS)
  ) u_digits (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .display_value_i(display_value_i),
    .word_valid_o   (word_valid),
    .word_ready_i   (word_ready),
    .word_o         (word)
  );

  assign last       = cnt_q == CntW'(WORD_BITS - 1);
  assign out_fire   = busy_q && !out_stall_i;
  assign word_ready = !busy_q || (out_fire && last);
  assign load       = word_valid && word_ready;
  assign shift      = out_fire && !last;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cells
    logic next_bit;
    if (i == WORD_BITS - 1) begin : g_end
      assign next_bit = 1'b0;
    end else begin : g_mid
      assign next_bit = cell_bits[i+1];
    end
    tdss_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load),
      .shift_i   (shift),
      .load_bit_i(word[i]),
      .next_bit_i(next_bit),
      .bit_o     (cell_bits[i])
    );
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (out_fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign out_valid_o  = busy_q;
  assign serial_bit_o = cell_bits[0];
  assign latch_now_o  = last;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the three-digit seven-segment shifter: directed and random values, bit-level check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic serial_bit;
    logic latch_now;
  } seg_bit_t;

  // Segment patterns for the hundreds and units (PCDE--------GFAB).
  localparam logic [15:0] EdgeDigitSeg [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };
  // Segment patterns for the tens (----PCDEGFAB----).
  localparam logic [15:0] TensDigitSeg [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };
  localparam int SegWordBits = 32;
  localparam int RandomValues = 350;

  class ShiftWordChecker;
    seg_bit_t pending_bits[$];
    int       mismatches = 0;

    function logic [31:0] segment_word_for(logic [15:0] value);
      int shown;
      shown = int'(value) % 1000;
      return {EdgeDigitSeg[shown / 100],
              TensDigitSeg[(shown / 10) % 10] | EdgeDigitSeg[shown % 10]};
    endfunction

    // One accepted value expands into the full word, least significant bit first.
    function void note_value(logic [15:0] value);
      logic [31:0] word;
      seg_bit_t    b;
      word = segment_word_for(value);
      for (int k = 0; k < SegWordBits; k++) begin
        b.serial_bit = word[k];
        b.latch_now  = (k == SegWordBits - 1);
        pending_bits.push_back(b);
      end
    endfunction

    function void check_bit(logic serial_bit, logic latch_now);
      seg_bit_t want;
      if (pending_bits.size() == 0) begin
        $error("unexpected output beat: serial_bit=%0b latch_now=%0b", serial_bit, latch_now);
        mismatches++;
        return;
      end
      want = pending_bits.pop_front();
      if (serial_bit !== want.serial_bit) begin
        $error("serial_bit: expected %0b, got %0b", want.serial_bit, serial_bit);
        mismatches++;
      end
      if (latch_now !== want.latch_now) begin
        $error("latch_now: expected %0b, got %0b", want.latch_now, latch_now);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  logic [15:0] display_value;
  logic        out_valid_o;
  logic        out_stall;
  logic        serial_bit_o;
  logic        latch_now_o;

  ShiftWordChecker words = new();

  three_digit_seven_segment_shifter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .display_value_i(display_value),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .serial_bit_o   (serial_bit_o),
    .latch_now_o    (latch_now_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver stall pattern: modes of random length with no stall, sparse stalls,
  // or a periodic stall window.
  int stall_mode;
  int stall_left = 0;
  int stall_period;
  int stall_len;
  int stall_phase;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode   = $urandom_range(0, 2);
      stall_left   = $urandom_range(50, 300);
      stall_period = $urandom_range(4, 16);
      stall_len    = $urandom_range(1, stall_period / 2);
      stall_phase  = 0;
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= (stall_phase < stall_len);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      words.check_bit(serial_bit_o, latch_now_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_value(input logic [15:0] value);
    in_valid      <= 1'b1;
    display_value <= value;
    do @(posedge clk_i); while (in_stall_o);
    words.note_value(value);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid      <= 1'b0;
    display_value <= 16'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  // Mix of in-range values, full-width values, digit-eight-heavy values and the top end.
  function automatic logic [15:0] pick_value();
    int d [3];
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 999));
      3, 4, 5: return 16'($urandom);
      6, 7, 8: begin
        foreach (d[i]) d[i] = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 9);
        return 16'($urandom_range(0, 64) * 1000 + d[0] * 100 + d[1] * 10 + d[2]);
      end
      default: return 16'(65535 - $urandom_range(0, 40));
    endcase
  endfunction

  logic [15:0] directed_values [22] = '{
    16'd0, 16'd1, 16'd8, 16'd88, 16'd888, 16'd808, 16'd999, 16'd123, 16'd456,
    16'd789, 16'd90, 16'd900, 16'd1000, 16'd1008, 16'd8888, 16'd12345,
    16'd65000, 16'd65535, 16'h5555, 16'hAAAA, 16'd7, 16'd500
  };

  initial begin
    int sent;
    int burst;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    display_value = 16'd0;
    out_stall     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 40));
    end

    sent = 0;
    while (sent < RandomValues) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < RandomValues; k++) begin
        send_value(pick_value());
        sent++;
      end
      // Back-to-back bursts now and then; otherwise gaps that land on any bit phase.
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end
    in_valid <= 1'b0;

    while (words.pending_bits.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (words.mismatches == 0 && words.pending_bits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tdss_pkg.sv
src/tdss_digits.sv
src/tdss_cell.sv
src/three_digit_seven_segment_shifter_top.sv
tb/sv/tb_top.sv
